// ===== design/sync_frame_parser_sum_checksum_core_defines.svh =====
// assertion macros for the sync frame parser core
`ifndef SYNC_FRAME_PARSER_SUM_CHECKSUM_CORE_DEFINES_SVH
`define SYNC_FRAME_PARSER_SUM_CHECKSUM_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFPSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfpsc check failed");

// next-cycle implication, sampled on clk, off during reset
`define SFPSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfpsc check failed");

`endif

// ===== design/sfpsc_pkg.sv =====
// types and constants shared by the sync frame parser files
package sfpsc_pkg;

	// parser phases
	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_ID     = 3'd1;
	localparam logic [2:0] PH_MID    = 3'd2;
	localparam logic [2:0] PH_LEN    = 3'd3;
	localparam logic [2:0] PH_LEN_HI = 3'd4;
	localparam logic [2:0] PH_LEN_LO = 3'd5;
	localparam logic [2:0] PH_DATA   = 3'd6;
	localparam logic [2:0] PH_CSUM   = 3'd7;

	// frame bytes
	localparam logic [7:0] PREAMBLE = 8'hFA;
	localparam logic [7:0] BUS_ID   = 8'hFF;
	localparam logic [7:0] LEN_EXT  = 8'hFF;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CSUM_ERR = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_SYNC_TMO = 2'd3;

	localparam logic [15:0] LIMIT_RESET = 16'd1000;

	typedef struct packed {
		logic [2:0]  phase;
		logic [15:0] attempt;
		logic [7:0]  mid;
		logic [15:0] len;
		logic [15:0] seen;
		logic [7:0]  sum;
	} state_t;

	typedef struct packed {
		logic        vld;
		logic [7:0]  payload_byte;
		logic [11:0] byte_index;
		logic [7:0]  message_id;
		logic [15:0] frame_length;
		logic        end_of_frame;
		logic [1:0]  status;
	} res_t;

endpackage

// ===== design/sfpsc_step.sv =====
// next-state and result logic for one received byte
module sfpsc_step #(
	parameter int MAX_PAYLOAD = 2048
) (
	input  sfpsc_pkg::state_t cur,
	input  logic [7:0]        rx,
	input  logic [15:0]       limit,
	output sfpsc_pkg::state_t nxt,
	output sfpsc_pkg::res_t   res
);

	localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

	logic [15:0] attempt_inc;
	logic [15:0] seen_inc;
	logic [7:0]  sum_add;
	logic [15:0] len_lo;

	assign attempt_inc = cur.attempt + 16'd1;
	assign seen_inc    = cur.seen + 16'd1;
	assign sum_add     = cur.sum + rx;
	assign len_lo      = cur.len | {8'd0, rx};

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cur.phase) inside
			sfpsc_pkg::PH_HUNT, sfpsc_pkg::PH_ID: begin
				if (cur.phase == sfpsc_pkg::PH_HUNT && rx == sfpsc_pkg::PREAMBLE) begin
					nxt.phase = sfpsc_pkg::PH_ID;
				end else if (cur.phase == sfpsc_pkg::PH_ID && rx == sfpsc_pkg::BUS_ID) begin
					nxt.attempt = '0;
					nxt.sum     = rx;
					nxt.phase   = sfpsc_pkg::PH_MID;
				end else begin
					// failed sync attempt
					nxt.phase = sfpsc_pkg::PH_HUNT;
					if (attempt_inc >= limit) begin
						nxt.attempt      = '0;
						res.vld          = 1'b1;
						res.end_of_frame = 1'b1;
						res.status       = sfpsc_pkg::ST_SYNC_TMO;
					end else begin
						nxt.attempt = attempt_inc;
					end
				end
			end
			sfpsc_pkg::PH_MID: begin
				nxt.mid   = rx;
				nxt.sum   = sum_add;
				nxt.phase = sfpsc_pkg::PH_LEN;
			end
			sfpsc_pkg::PH_LEN, sfpsc_pkg::PH_LEN_LO: begin
				nxt.sum = sum_add;
				if (cur.phase == sfpsc_pkg::PH_LEN && rx == sfpsc_pkg::LEN_EXT) begin
					nxt.phase = sfpsc_pkg::PH_LEN_HI;
				end else begin
					// length complete
					nxt.len  = (cur.phase == sfpsc_pkg::PH_LEN) ? {8'd0, rx} : len_lo;
					nxt.seen = '0;
					if (nxt.len > MaxLen) begin
						nxt.phase        = sfpsc_pkg::PH_HUNT;
						res.vld          = 1'b1;
						res.message_id   = cur.mid;
						res.frame_length = nxt.len;
						res.end_of_frame = 1'b1;
						res.status       = sfpsc_pkg::ST_TOO_LONG;
					end else if (nxt.len == 16'd0) begin
						nxt.phase = sfpsc_pkg::PH_CSUM;
					end else begin
						nxt.phase = sfpsc_pkg::PH_DATA;
					end
				end
			end
			sfpsc_pkg::PH_LEN_HI: begin
				nxt.sum   = sum_add;
				nxt.len   = {rx, 8'd0};
				nxt.phase = sfpsc_pkg::PH_LEN_LO;
			end
			sfpsc_pkg::PH_DATA: begin
				nxt.sum          = sum_add;
				nxt.seen         = seen_inc;
				res.vld          = 1'b1;
				res.payload_byte = rx;
				res.byte_index   = cur.seen[11:0];
				res.message_id   = cur.mid;
				res.frame_length = cur.len;
				if (seen_inc >= cur.len) begin
					nxt.phase = sfpsc_pkg::PH_CSUM;
				end
			end
			sfpsc_pkg::PH_CSUM: begin
				nxt.sum          = sum_add;
				nxt.phase        = sfpsc_pkg::PH_HUNT;
				res.vld          = 1'b1;
				res.byte_index   = cur.len[11:0];
				res.message_id   = cur.mid;
				res.frame_length = cur.len;
				res.end_of_frame = 1'b1;
				res.status       = (sum_add == 8'd0) ? sfpsc_pkg::ST_OK
					: sfpsc_pkg::ST_CSUM_ERR;
			end
			default: begin
				nxt.phase = sfpsc_pkg::PH_HUNT;
			end
		endcase
	end

endmodule

// ===== design/sync_frame_parser_sum_checksum_core.sv =====
// top level of the sync frame parser with 8-bit sum checksum
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  input    | in_valid / in_ready   | rx_byte
//  output   | out_valid / out_ready | payload_byte, byte_index, message_id,
//           |                       | frame_length, end_of_frame, status
//  config   | cfg_wr_en             | cfg_wr_data (sync attempt limit)
//
// one byte per cycle while no held result stalls it; a byte is registered at input, runs
// through the phase and sum update, and its result is then registered in the output register.
// arst_n clears the phase, counters, sum and valid flags; the limit resets to 1000.
// a held output result stalls the input register whether or not the byte there
// gives a result, and in_ready then follows out_ready combinationally.
`include "sync_frame_parser_sum_checksum_core_defines.svh"

module sync_frame_parser_sum_checksum_core #(
	parameter int MAX_PAYLOAD = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic [11:0] byte_index,
	output logic [7:0]  message_id,
	output logic [15:0] frame_length,
	output logic        end_of_frame,
	output logic [1:0]  status,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic [15:0]       limit_q;
	logic              valid_s1;
	logic [7:0]        rx_s1;
	sfpsc_pkg::state_t state_q;
	sfpsc_pkg::state_t state_nxt;
	sfpsc_pkg::res_t   res_nxt;
	logic              valid_s2;
	sfpsc_pkg::res_t   res_s2;
	logic              out_free;
	logic              advance;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sfpsc_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// flow control
	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	// per-byte update
	sfpsc_step #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_step (
		.cur   (state_q),
		.rx    (rx_s1),
		.limit (limit_q),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: sfpsc_pkg::PH_HUNT, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res_nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_nxt.vld) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign payload_byte = res_s2.payload_byte;
	assign byte_index   = res_s2.byte_index;
	assign message_id   = res_s2.message_id;
	assign frame_length = res_s2.frame_length;
	assign end_of_frame = res_s2.end_of_frame;
	assign status       = res_s2.status;

	// checks
	`SFPSC_ASSERT_NOW(a_payload_ok, valid_s2 && !res_s2.end_of_frame, res_s2.status == sfpsc_pkg::ST_OK)
	`SFPSC_ASSERT_NOW(a_data_in_range, state_q.phase == sfpsc_pkg::PH_DATA, state_q.seen < state_q.len)
	`SFPSC_ASSERT_NOW(a_tmo_clear, valid_s2 && res_s2.status == sfpsc_pkg::ST_SYNC_TMO, res_s2.end_of_frame && res_s2.frame_length == 16'd0)
	`SFPSC_ASSERT_NEXT(a_tmo_resets_count, advance && res_nxt.vld && res_nxt.status == sfpsc_pkg::ST_SYNC_TMO, state_q.attempt == 16'd0)

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the sync frame parser core with 8-bit sum checksum
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_PAYLOAD      = 2048;
	localparam int CYCLE_LIMIT      = 1000000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_BUDGET     = 160;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [11:0] byte_index;
		logic [7:0]  message_id;
		logic [15:0] frame_length;
		logic        end_of_frame;
		logic [1:0]  status;
	} frame_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  payload_byte;
	logic [11:0] byte_index;
	logic [7:0]  message_id;
	logic [15:0] frame_length;
	logic        end_of_frame;
	logic [1:0]  status;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;

	// bytes waiting to be sent, and parser results still owed by the block
	logic [7:0]    rx_stream[$];
	frame_result_t parser_outputs_due[$];

	// predicted parser state
	logic [2:0]  rx_phase = sfpsc_pkg::PH_HUNT;
	logic [15:0] sync_fails = 16'd0;
	logic [15:0] sync_limit = sfpsc_pkg::LIMIT_RESET;
	logic [7:0]  frame_mid = 8'd0;
	logic [15:0] frame_len = 16'd0;
	logic [15:0] payload_count = 16'd0;
	logic [7:0]  frame_sum = 8'd0;

	// flow control knobs
	bit in_taken = 1'b0;
	bit idle_enable = 1'b1;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int send_gap = 0;
	int recv_gap = 0;
	logic long_hold = 1'b0;
	int hold_requests = 0;
	int holds_served = 0;

	int mismatch_count = 0;
	int cycle_count = 0;
	int bytes_queued = 0;

	sync_frame_parser_sum_checksum_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.byte_index(byte_index),
		.message_id(message_id),
		.frame_length(frame_length),
		.end_of_frame(end_of_frame),
		.status(status),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// preamble or id miss, with sync timeout once the limit is hit
	task automatic count_sync_failure();
		rx_phase = sfpsc_pkg::PH_HUNT;
		sync_fails = sync_fails + 16'd1;
		if (sync_fails >= sync_limit) begin
			sync_fails = 16'd0;
			parser_outputs_due.push_back(frame_result_t'{8'd0, 12'd0, 8'd0, 16'd0, 1'b1,
				sfpsc_pkg::ST_SYNC_TMO});
		end
	endtask

	// length fully received: reject, skip to checksum, or start payload
	task automatic close_length();
		payload_count = 16'd0;
		if (frame_len > MAX_PAYLOAD) begin
			rx_phase = sfpsc_pkg::PH_HUNT;
			parser_outputs_due.push_back(frame_result_t'{8'd0, 12'd0, frame_mid, frame_len,
				1'b1, sfpsc_pkg::ST_TOO_LONG});
		end else if (frame_len == 16'd0) begin
			rx_phase = sfpsc_pkg::PH_CSUM;
		end else begin
			rx_phase = sfpsc_pkg::PH_DATA;
		end
	endtask

	// advance the predicted parser by one received byte
	task automatic parse_rx_byte(input logic [7:0] b);
		case (rx_phase)
			sfpsc_pkg::PH_HUNT: begin
				if (b == sfpsc_pkg::PREAMBLE)
					rx_phase = sfpsc_pkg::PH_ID;
				else
					count_sync_failure();
			end
			sfpsc_pkg::PH_ID: begin
				if (b != sfpsc_pkg::BUS_ID) begin
					count_sync_failure();
				end else begin
					sync_fails = 16'd0;
					frame_sum = b;
					rx_phase = sfpsc_pkg::PH_MID;
				end
			end
			sfpsc_pkg::PH_MID: begin
				frame_mid = b;
				frame_sum = frame_sum + b;
				rx_phase = sfpsc_pkg::PH_LEN;
			end
			sfpsc_pkg::PH_LEN: begin
				frame_sum = frame_sum + b;
				if (b == sfpsc_pkg::LEN_EXT) begin
					rx_phase = sfpsc_pkg::PH_LEN_HI;
				end else begin
					frame_len = {8'd0, b};
					close_length();
				end
			end
			sfpsc_pkg::PH_LEN_HI: begin
				frame_sum = frame_sum + b;
				frame_len = {b, 8'd0};
				rx_phase = sfpsc_pkg::PH_LEN_LO;
			end
			sfpsc_pkg::PH_LEN_LO: begin
				frame_sum = frame_sum + b;
				frame_len = frame_len | {8'd0, b};
				close_length();
			end
			sfpsc_pkg::PH_DATA: begin
				frame_sum = frame_sum + b;
				parser_outputs_due.push_back(frame_result_t'{b, payload_count[11:0], frame_mid,
					frame_len, 1'b0, sfpsc_pkg::ST_OK});
				payload_count = payload_count + 16'd1;
				if (payload_count >= frame_len)
					rx_phase = sfpsc_pkg::PH_CSUM;
			end
			default: begin
				frame_sum = frame_sum + b;
				rx_phase = sfpsc_pkg::PH_HUNT;
				parser_outputs_due.push_back(frame_result_t'{8'd0, frame_len[11:0], frame_mid,
					frame_len, 1'b1,
					(frame_sum == 8'd0) ? sfpsc_pkg::ST_OK : sfpsc_pkg::ST_CSUM_ERR});
			end
		endcase
	endtask

	// sample handshakes, predict and check
	always @(posedge clk) begin : monitor
		frame_result_t got;
		frame_result_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("testbench failed");
				$finish;
			end else begin
				if (out_valid && out_ready) begin
					got = '{payload_byte, byte_index, message_id, frame_length, end_of_frame,
						status};
					if (parser_outputs_due.size() == 0) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("unexpected item: byte %h idx %0d mid %h len %0d eof %b st %0d",
								got.payload_byte, got.byte_index, got.message_id,
								got.frame_length, got.end_of_frame, got.status);
					end else begin
						want = parser_outputs_due.pop_front();
						if (got.payload_byte !== want.payload_byte ||
								got.byte_index !== want.byte_index ||
								got.message_id !== want.message_id ||
								got.frame_length !== want.frame_length ||
								got.end_of_frame !== want.end_of_frame ||
								got.status !== want.status) begin
							mismatch_count++;
							if (mismatch_count <= 10)
								$display({"mismatch: exp byte %h idx %0d mid %h len %0d eof %b st %0d,",
									" got byte %h idx %0d mid %h len %0d eof %b st %0d"},
									want.payload_byte, want.byte_index, want.message_id,
									want.frame_length, want.end_of_frame, want.status,
									got.payload_byte, got.byte_index, got.message_id,
									got.frame_length, got.end_of_frame, got.status);
						end
					end
				end
				in_taken = in_valid && in_ready;
				if (in_taken)
					parse_rx_byte(rx_byte);
				if (cfg_wr_en)
					sync_limit = cfg_wr_data;
			end
		end
	end

	// sender: next byte once the current one is taken, with random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (rx_stream.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= rx_stream.pop_front();
				if (idle_enable && $urandom_range(99) < send_idle_pct)
					send_gap <= $urandom_range(1, 17);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: ready with random stall bursts, or held off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold) begin
				out_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_enable && $urandom_range(99) < recv_idle_pct)
					recv_gap <= $urandom_range(1, 17);
			end
		end
	end

	// long receiver hold-off, counted here
	always begin
		@(negedge clk);
		if (hold_requests != holds_served) begin
			long_hold <= 1'b1;
			repeat (LONG_HOLD_CYCLES) @(negedge clk);
			long_hold <= 1'b0;
			holds_served++;
		end
	end

	task automatic put_byte(input logic [7:0] b);
		rx_stream.push_back(b);
		bytes_queued++;
	endtask

	// full frame, or only its header when len exceeds MAX_PAYLOAD; fill < 0 gives random payload, else a constant byte
	task automatic queue_frame(input logic [7:0] mid, input logic [15:0] len, input bit ext,
			input bit good, input int fill);
		logic [7:0] sum;
		logic [7:0] b;
		sum = sfpsc_pkg::BUS_ID + mid;
		put_byte(sfpsc_pkg::PREAMBLE);
		put_byte(sfpsc_pkg::BUS_ID);
		put_byte(mid);
		if (ext || len >= sfpsc_pkg::LEN_EXT) begin
			put_byte(sfpsc_pkg::LEN_EXT);
			put_byte(len[15:8]);
			put_byte(len[7:0]);
			sum = sum + sfpsc_pkg::LEN_EXT + len[15:8] + len[7:0];
		end else begin
			put_byte(len[7:0]);
			sum = sum + len[7:0];
		end
		if (len <= MAX_PAYLOAD) begin
			for (int i = 0; i < len; i++) begin
				b = (fill < 0) ? 8'($urandom) : fill[7:0];
				put_byte(b);
				sum = sum + b;
			end
			b = -sum;
			if (!good)
				b = b + 8'($urandom_range(1, 255));
			put_byte(b);
		end
	endtask

	// mostly well-formed frames, some noise and broken sequences
	task automatic queue_random_traffic(input int budget);
		int stop_at;
		int pick;
		stop_at = bytes_queued + budget;
		while (bytes_queued < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				queue_frame(8'($urandom), 16'($urandom_range(0, 12)), $urandom_range(9) == 0,
					1'b1, -1);
			end else if (pick < 70) begin
				queue_frame(8'($urandom), 16'($urandom_range(0, 12)), $urandom_range(3) == 0,
					1'b0, -1);
			end else if (pick < 74) begin
				queue_frame(8'($urandom), 16'($urandom_range(13, 300)), 1'b0, 1'b1, -1);
			end else if (pick < 78) begin
				queue_frame(8'($urandom), 16'($urandom_range(MAX_PAYLOAD + 1, 65535)), 1'b1,
					1'b1, -1);
			end else if (pick < 84) begin
				put_byte(sfpsc_pkg::PREAMBLE);
				put_byte(8'($urandom_range(0, 254)));
			end else if (pick < 90) begin
				// header cut short, the rest is line noise
				put_byte(sfpsc_pkg::PREAMBLE);
				put_byte(sfpsc_pkg::BUS_ID);
				repeat ($urandom_range(1, 5)) put_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
			end
		end
	endtask

	// block idle: no byte left, nothing owed, then a settling wait
	task automatic wait_quiet();
		while (rx_stream.size() != 0 || in_valid || parser_outputs_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync_limit(input logic [15:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [15:0] limits[7];
		limits = '{16'd2, 16'd65535, 16'd1, 16'd3, 16'd7, 16'd1000, 16'd4};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset limit
		send_idle_pct = 20;
		recv_idle_pct = 20;
		queue_frame(8'h00, 16'd0, 1'b0, 1'b1, -1);
		queue_frame(8'hFF, 16'd1, 1'b0, 1'b0, 8'h00);
		queue_frame(8'h5A, 16'd2, 1'b0, 1'b1, 8'hFF);
		queue_frame(8'h01, 16'd0, 1'b1, 1'b1, -1);
		queue_frame(8'h02, 16'd255, 1'b1, 1'b1, -1);
		queue_frame(8'h03, 16'(MAX_PAYLOAD + 1), 1'b1, 1'b1, -1);
		queue_frame(8'h04, 16'hFFFF, 1'b1, 1'b1, -1);
		put_byte(sfpsc_pkg::PREAMBLE);
		put_byte(8'h12);
		// second preamble in the id slot is dropped, not taken as a new start
		put_byte(sfpsc_pkg::PREAMBLE);
		put_byte(sfpsc_pkg::PREAMBLE);
		put_byte(sfpsc_pkg::BUS_ID);
		queue_frame(8'hA5, 16'd1, 1'b0, 1'b1, sfpsc_pkg::PREAMBLE);
		wait_quiet();

		// limit of one: every miss times out
		write_sync_limit(16'd1);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(sfpsc_pkg::PREAMBLE);
		put_byte(8'h00);
		queue_frame(8'h3C, 16'd3, 1'b0, 1'b1, -1);
		wait_quiet();

		// random phases across several limits
		for (int p = 0; p < 7; p++) begin
			write_sync_limit(limits[p]);
			idle_enable = (p != 6);
			send_idle_pct = (p == 3) ? 0 : $urandom_range(5, 40);
			recv_idle_pct = (p == 3) ? 0 : $urandom_range(5, 40);
			if (p == 1) begin
				send_idle_pct = 0;
				hold_requests++;
			end
			queue_random_traffic(PHASE_BUDGET);
			wait_quiet();
		end

		if (mismatch_count == 0 && parser_outputs_due.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
